// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with an explicit clock and active-low reset.
`define LOD_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define LOD_ASSERT(name, prop, msg) \
  `LOD_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/lod_pkg.sv =====
// ----------------------------------------------------------------------------
// lod_pkg
// Types, register codes and the control store of the Lorenz integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lod_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = 2 * WORD_W;
  localparam int unsigned RADDR_W  = 5;
  localparam int unsigned PC_W     = 8;
  localparam int unsigned METHOD_W = 3;
  localparam int unsigned STEP_W   = 17;
  localparam int unsigned CIDX_W   = 3;

  // ceil(2^33 / 3): (n * RECIP3) >> 34 is n / 6 for any 32-bit n
  localparam logic [WORD_W-1:0] RECIP3      = 32'hAAAA_AAAB;
  localparam int unsigned       RECIP_SHIFT = 34;

  typedef enum logic [3:0] {
    OP_NOP, OP_ADD, OP_SUB, OP_MOV, OP_MUL, OP_MUL6, OP_RND, OP_Q6, OP_DIV2,
    OP_CALL, OP_RET, OP_DISP, OP_DONE
  } op_e;

  typedef logic [RADDR_W-1:0] raddr_t;
  typedef logic [PC_W-1:0]    pc_t;

  // operand space: below R_NX are flops (point, coefficients), from R_NX up is the file
  localparam raddr_t R_PX  = 5'd0;
  localparam raddr_t R_PY  = 5'd1;
  localparam raddr_t R_PZ  = 5'd2;
  localparam raddr_t R_SIG = 5'd3;
  localparam raddr_t R_RHO = 5'd4;
  localparam raddr_t R_BET = 5'd5;
  localparam raddr_t R_H   = 5'd6;
  localparam raddr_t R_NX  = 5'd8;
  localparam raddr_t R_NY  = 5'd9;
  localparam raddr_t R_NZ  = 5'd10;
  localparam raddr_t R_DX  = 5'd11;
  localparam raddr_t R_DY  = 5'd12;
  localparam raddr_t R_DZ  = 5'd13;
  localparam raddr_t R_SX  = 5'd14;
  localparam raddr_t R_SY  = 5'd15;
  localparam raddr_t R_SZ  = 5'd16;
  localparam raddr_t R_T   = 5'd17;
  localparam raddr_t R_L   = 5'd18;
  localparam raddr_t R_U   = 5'd19;

  localparam logic [METHOD_W-1:0] M_EULER = 3'd0;
  localparam logic [METHOD_W-1:0] M_RK4   = 3'd1;
  localparam logic [METHOD_W-1:0] M_MID   = 3'd2;
  localparam logic [METHOD_W-1:0] M_EC    = 3'd3;
  localparam logic [METHOD_W-1:0] M_SYM   = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_METHOD = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SIGMA  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RHO    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BETA   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STEP   = 3'd4;

  localparam pc_t PC_LX  = 8'd4;
  localparam pc_t PC_LY  = 8'd8;
  localparam pc_t PC_LZ  = 8'd13;
  localparam pc_t PC_END = 8'd19;
  localparam pc_t PC_EUL = 8'd20;
  localparam pc_t PC_MID = 8'd33;
  localparam pc_t PC_RK4 = 8'd61;
  localparam pc_t PC_EC  = 8'd140;
  localparam pc_t PC_SYM = 8'd156;

  typedef struct packed {
    op_e    op;
    raddr_t dst;
    raddr_t a;
    raddr_t b;
    pc_t    tgt;
  } uword_t;

  typedef struct packed {
    op_e    op;
    raddr_t dst;
    raddr_t a;
    raddr_t b;
    logic   rd;
    logic   ex;
  } ctl_t;

  typedef struct packed {
    logic [METHOD_W-1:0] method;
    logic [WORD_W-1:0]   sigma;
    logic [WORD_W-1:0]   rho;
    logic [WORD_W-1:0]   beta;
    logic [STEP_W-1:0]   h;
  } cfg_t;

  function automatic uword_t uw(op_e op, raddr_t d, raddr_t a, raddr_t b, pc_t t);
    uword_t w;
    w.op  = op;
    w.dst = d;
    w.a   = a;
    w.b   = b;
    w.tgt = t;
    return w;
  endfunction

  function automatic uword_t i_mov(raddr_t d, raddr_t a);
    return uw(OP_MOV, d, a, R_PX, '0);
  endfunction
  function automatic uword_t i_add(raddr_t d, raddr_t a, raddr_t b);
    return uw(OP_ADD, d, a, b, '0);
  endfunction
  function automatic uword_t i_sub(raddr_t d, raddr_t a, raddr_t b);
    return uw(OP_SUB, d, a, b, '0);
  endfunction
  function automatic uword_t i_mul(raddr_t a, raddr_t b);
    return uw(OP_MUL, R_PX, a, b, '0);
  endfunction
  function automatic uword_t i_mul6(raddr_t a);
    return uw(OP_MUL6, R_PX, a, R_PX, '0);
  endfunction
  function automatic uword_t i_rnd(raddr_t d);
    return uw(OP_RND, d, R_PX, R_PX, '0);
  endfunction
  function automatic uword_t i_q6(raddr_t d);
    return uw(OP_Q6, d, R_PX, R_PX, '0);
  endfunction
  function automatic uword_t i_div2(raddr_t d, raddr_t a);
    return uw(OP_DIV2, d, a, R_PX, '0);
  endfunction
  function automatic uword_t i_call(pc_t t);
    return uw(OP_CALL, R_PX, R_PX, R_PX, t);
  endfunction
  function automatic uword_t i_ctl(op_e op);
    return uw(op, R_PX, R_PX, R_PX, '0);
  endfunction

  function automatic pc_t method_entry(logic [METHOD_W-1:0] m);
    pc_t p;
    case (m)
      M_EULER: p = PC_EUL;
      M_RK4:   p = PC_RK4;
      M_MID:   p = PC_MID;
      M_EC:    p = PC_EC;
      M_SYM:   p = PC_SYM;
      default: p = PC_END;
    endcase
    return p;
  endfunction

  // Control store. Lorenz terms are subroutines LX/LY/LZ reading N, writing D.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      // copy point to the working point, then branch on method
      8'd0:   w = i_mov(R_NX, R_PX);
      8'd1:   w = i_mov(R_NY, R_PY);
      8'd2:   w = i_mov(R_NZ, R_PZ);
      8'd3:   w = i_ctl(OP_DISP);
      // LX: sigma*(y-x)
      8'd4:   w = i_sub(R_L, R_NY, R_NX);
      8'd5:   w = i_mul(R_SIG, R_L);
      8'd6:   w = i_rnd(R_DX);
      8'd7:   w = i_ctl(OP_RET);
      // LY: x*(rho-z) - y
      8'd8:   w = i_sub(R_L, R_RHO, R_NZ);
      8'd9:   w = i_mul(R_NX, R_L);
      8'd10:  w = i_rnd(R_L);
      8'd11:  w = i_sub(R_DY, R_L, R_NY);
      8'd12:  w = i_ctl(OP_RET);
      // LZ: x*y - beta*z
      8'd13:  w = i_mul(R_NX, R_NY);
      8'd14:  w = i_rnd(R_L);
      8'd15:  w = i_mul(R_BET, R_NZ);
      8'd16:  w = i_rnd(R_U);
      8'd17:  w = i_sub(R_DZ, R_L, R_U);
      8'd18:  w = i_ctl(OP_RET);
      8'd19:  w = i_ctl(OP_DONE);
      // Euler
      8'd20:  w = i_call(PC_LX);
      8'd21:  w = i_call(PC_LY);
      8'd22:  w = i_call(PC_LZ);
      8'd23:  w = i_mul(R_H, R_DX);
      8'd24:  w = i_rnd(R_T);
      8'd25:  w = i_add(R_PX, R_PX, R_T);
      8'd26:  w = i_mul(R_H, R_DY);
      8'd27:  w = i_rnd(R_T);
      8'd28:  w = i_add(R_PY, R_PY, R_T);
      8'd29:  w = i_mul(R_H, R_DZ);
      8'd30:  w = i_rnd(R_T);
      8'd31:  w = i_add(R_PZ, R_PZ, R_T);
      8'd32:  w = i_ctl(OP_DONE);
      // midpoint
      8'd33:  w = i_call(PC_LX);
      8'd34:  w = i_call(PC_LY);
      8'd35:  w = i_call(PC_LZ);
      8'd36:  w = i_mul(R_H, R_DX);
      8'd37:  w = i_rnd(R_T);
      8'd38:  w = i_div2(R_T, R_T);
      8'd39:  w = i_add(R_NX, R_PX, R_T);
      8'd40:  w = i_mul(R_H, R_DY);
      8'd41:  w = i_rnd(R_T);
      8'd42:  w = i_div2(R_T, R_T);
      8'd43:  w = i_add(R_NY, R_PY, R_T);
      8'd44:  w = i_mul(R_H, R_DZ);
      8'd45:  w = i_rnd(R_T);
      8'd46:  w = i_div2(R_T, R_T);
      8'd47:  w = i_add(R_NZ, R_PZ, R_T);
      8'd48:  w = i_call(PC_LX);
      8'd49:  w = i_call(PC_LY);
      8'd50:  w = i_call(PC_LZ);
      8'd51:  w = i_mul(R_H, R_DX);
      8'd52:  w = i_rnd(R_T);
      8'd53:  w = i_add(R_PX, R_PX, R_T);
      8'd54:  w = i_mul(R_H, R_DY);
      8'd55:  w = i_rnd(R_T);
      8'd56:  w = i_add(R_PY, R_PY, R_T);
      8'd57:  w = i_mul(R_H, R_DZ);
      8'd58:  w = i_rnd(R_T);
      8'd59:  w = i_add(R_PZ, R_PZ, R_T);
      8'd60:  w = i_ctl(OP_DONE);
      // RK4, k1
      8'd61:  w = i_call(PC_LX);
      8'd62:  w = i_call(PC_LY);
      8'd63:  w = i_call(PC_LZ);
      8'd64:  w = i_mov(R_SX, R_DX);
      8'd65:  w = i_mul(R_H, R_DX);
      8'd66:  w = i_rnd(R_T);
      8'd67:  w = i_div2(R_T, R_T);
      8'd68:  w = i_add(R_NX, R_PX, R_T);
      8'd69:  w = i_mov(R_SY, R_DY);
      8'd70:  w = i_mul(R_H, R_DY);
      8'd71:  w = i_rnd(R_T);
      8'd72:  w = i_div2(R_T, R_T);
      8'd73:  w = i_add(R_NY, R_PY, R_T);
      8'd74:  w = i_mov(R_SZ, R_DZ);
      8'd75:  w = i_mul(R_H, R_DZ);
      8'd76:  w = i_rnd(R_T);
      8'd77:  w = i_div2(R_T, R_T);
      8'd78:  w = i_add(R_NZ, R_PZ, R_T);
      // k2
      8'd79:  w = i_call(PC_LX);
      8'd80:  w = i_call(PC_LY);
      8'd81:  w = i_call(PC_LZ);
      8'd82:  w = i_add(R_T, R_DX, R_DX);
      8'd83:  w = i_add(R_SX, R_SX, R_T);
      8'd84:  w = i_mul(R_H, R_DX);
      8'd85:  w = i_rnd(R_T);
      8'd86:  w = i_div2(R_T, R_T);
      8'd87:  w = i_add(R_NX, R_PX, R_T);
      8'd88:  w = i_add(R_T, R_DY, R_DY);
      8'd89:  w = i_add(R_SY, R_SY, R_T);
      8'd90:  w = i_mul(R_H, R_DY);
      8'd91:  w = i_rnd(R_T);
      8'd92:  w = i_div2(R_T, R_T);
      8'd93:  w = i_add(R_NY, R_PY, R_T);
      8'd94:  w = i_add(R_T, R_DZ, R_DZ);
      8'd95:  w = i_add(R_SZ, R_SZ, R_T);
      8'd96:  w = i_mul(R_H, R_DZ);
      8'd97:  w = i_rnd(R_T);
      8'd98:  w = i_div2(R_T, R_T);
      8'd99:  w = i_add(R_NZ, R_PZ, R_T);
      // k3
      8'd100: w = i_call(PC_LX);
      8'd101: w = i_call(PC_LY);
      8'd102: w = i_call(PC_LZ);
      8'd103: w = i_add(R_T, R_DX, R_DX);
      8'd104: w = i_add(R_SX, R_SX, R_T);
      8'd105: w = i_mul(R_H, R_DX);
      8'd106: w = i_rnd(R_T);
      8'd107: w = i_add(R_NX, R_PX, R_T);
      8'd108: w = i_add(R_T, R_DY, R_DY);
      8'd109: w = i_add(R_SY, R_SY, R_T);
      8'd110: w = i_mul(R_H, R_DY);
      8'd111: w = i_rnd(R_T);
      8'd112: w = i_add(R_NY, R_PY, R_T);
      8'd113: w = i_add(R_T, R_DZ, R_DZ);
      8'd114: w = i_add(R_SZ, R_SZ, R_T);
      8'd115: w = i_mul(R_H, R_DZ);
      8'd116: w = i_rnd(R_T);
      8'd117: w = i_add(R_NZ, R_PZ, R_T);
      // k4 and the weighted update
      8'd118: w = i_call(PC_LX);
      8'd119: w = i_call(PC_LY);
      8'd120: w = i_call(PC_LZ);
      8'd121: w = i_add(R_SX, R_SX, R_DX);
      8'd122: w = i_mul(R_H, R_SX);
      8'd123: w = i_rnd(R_T);
      8'd124: w = i_mul6(R_T);
      8'd125: w = i_q6(R_T);
      8'd126: w = i_add(R_PX, R_PX, R_T);
      8'd127: w = i_add(R_SY, R_SY, R_DY);
      8'd128: w = i_mul(R_H, R_SY);
      8'd129: w = i_rnd(R_T);
      8'd130: w = i_mul6(R_T);
      8'd131: w = i_q6(R_T);
      8'd132: w = i_add(R_PY, R_PY, R_T);
      8'd133: w = i_add(R_SZ, R_SZ, R_DZ);
      8'd134: w = i_mul(R_H, R_SZ);
      8'd135: w = i_rnd(R_T);
      8'd136: w = i_mul6(R_T);
      8'd137: w = i_q6(R_T);
      8'd138: w = i_add(R_PZ, R_PZ, R_T);
      8'd139: w = i_ctl(OP_DONE);
      // Euler-Cromer: each axis sees the axes already updated
      8'd140: w = i_call(PC_LX);
      8'd141: w = i_mul(R_H, R_DX);
      8'd142: w = i_rnd(R_T);
      8'd143: w = i_add(R_NX, R_PX, R_T);
      8'd144: w = i_call(PC_LY);
      8'd145: w = i_mul(R_H, R_DY);
      8'd146: w = i_rnd(R_T);
      8'd147: w = i_add(R_NY, R_PY, R_T);
      8'd148: w = i_call(PC_LZ);
      8'd149: w = i_mul(R_H, R_DZ);
      8'd150: w = i_rnd(R_T);
      8'd151: w = i_add(R_NZ, R_PZ, R_T);
      8'd152: w = i_mov(R_PX, R_NX);
      8'd153: w = i_mov(R_PY, R_NY);
      8'd154: w = i_mov(R_PZ, R_NZ);
      8'd155: w = i_ctl(OP_DONE);
      // symmetric half steps x, y, z, z, y, x
      8'd156: w = i_call(PC_LX);
      8'd157: w = i_mul(R_H, R_DX);
      8'd158: w = i_rnd(R_T);
      8'd159: w = i_div2(R_T, R_T);
      8'd160: w = i_add(R_NX, R_NX, R_T);
      8'd161: w = i_call(PC_LY);
      8'd162: w = i_mul(R_H, R_DY);
      8'd163: w = i_rnd(R_T);
      8'd164: w = i_div2(R_T, R_T);
      8'd165: w = i_add(R_NY, R_NY, R_T);
      8'd166: w = i_call(PC_LZ);
      8'd167: w = i_mul(R_H, R_DZ);
      8'd168: w = i_rnd(R_T);
      8'd169: w = i_div2(R_T, R_T);
      8'd170: w = i_add(R_NZ, R_NZ, R_T);
      8'd171: w = i_call(PC_LZ);
      8'd172: w = i_mul(R_H, R_DZ);
      8'd173: w = i_rnd(R_T);
      8'd174: w = i_div2(R_T, R_T);
      8'd175: w = i_add(R_NZ, R_NZ, R_T);
      8'd176: w = i_call(PC_LY);
      8'd177: w = i_mul(R_H, R_DY);
      8'd178: w = i_rnd(R_T);
      8'd179: w = i_div2(R_T, R_T);
      8'd180: w = i_add(R_NY, R_NY, R_T);
      8'd181: w = i_call(PC_LX);
      8'd182: w = i_mul(R_H, R_DX);
      8'd183: w = i_rnd(R_T);
      8'd184: w = i_div2(R_T, R_T);
      8'd185: w = i_add(R_NX, R_NX, R_T);
      8'd186: w = i_mov(R_PX, R_NX);
      8'd187: w = i_mov(R_PY, R_NY);
      8'd188: w = i_mov(R_PZ, R_NZ);
      default: w = i_ctl(OP_DONE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lod_useq.sv =====
// ----------------------------------------------------------------------------
// lod_useq
// Microcode sequencer: program counter, return register, control store fetch.
// ----------------------------------------------------------------------------
`default_nettype none

module lod_useq import lod_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [METHOD_W-1:0] method_i,
  output ctl_t                ctl_o,
  output logic                done_o
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EX} state_e;

  state_e state_q;
  pc_t    pc_q;
  pc_t    ret_q;
  logic   done_q;
  uword_t uw_c;

  assign uw_c = ucode(pc_q);

  // each control word: an operand read state (S_RD), then an execute state (S_EX)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      ret_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            pc_q    <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_EX;
        S_EX: begin
          state_q <= S_RD;
          case (uw_c.op)
            OP_CALL: begin
              ret_q <= pc_q + pc_t'(1);
              pc_q  <= uw_c.tgt;
            end
            OP_RET:  pc_q <= ret_q;
            OP_DISP: pc_q <= method_entry(method_i);
            OP_DONE: begin
              state_q <= S_IDLE;
              done_q  <= 1'b1;
            end
            default: pc_q <= pc_q + pc_t'(1);
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl_o.op  = uw_c.op;
    ctl_o.dst = uw_c.dst;
    ctl_o.a   = uw_c.a;
    ctl_o.b   = uw_c.b;
    ctl_o.rd  = (state_q == S_RD);
    ctl_o.ex  = (state_q == S_EX);
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/lod_dpath.sv =====
// ----------------------------------------------------------------------------
// lod_dpath
// Datapath: register file, saturating adder, shared multiplier, rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module lod_dpath import lod_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  input  cfg_t              cfg_i,
  input  logic              load_i,
  input  logic [WORD_W-1:0] load_x_i,
  input  logic [WORD_W-1:0] load_y_i,
  input  logic [WORD_W-1:0] load_z_i,
  output logic [WORD_W-1:0] pos_x_o,
  output logic [WORD_W-1:0] pos_y_o,
  output logic [WORD_W-1:0] pos_z_o
);

  localparam int unsigned MW = PROD_W - FRAC_W;
  localparam int unsigned QW = PROD_W - RECIP_SHIFT;

  logic [WORD_W-1:0] mem [2**RADDR_W];
  logic [WORD_W-1:0] px_q, py_q, pz_q;
  logic [WORD_W-1:0] opa_q, opb_q;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;

  logic [WORD_W-1:0] spec_a, spec_b;
  logic [WORD_W:0]   sum_c, dif_c;
  logic [WORD_W-1:0] mag_a, mag_b, mul_x, mul_y, res_c;
  logic [PROD_W-1:0] prod_c, rnd_c;
  logic [WORD_W:0]   half_c;
  logic [WORD_W-1:0] half_m;
  logic              wr_en;

  function automatic logic [WORD_W-1:0] sel_spec(raddr_t r, logic [WORD_W-1:0] x,
                                                 logic [WORD_W-1:0] y, logic [WORD_W-1:0] z,
                                                 cfg_t c);
    logic [WORD_W-1:0] v;
    case (r)
      R_PX:    v = x;
      R_PY:    v = y;
      R_PZ:    v = z;
      R_SIG:   v = c.sigma;
      R_RHO:   v = c.rho;
      R_BET:   v = c.beta;
      R_H:     v = {{(WORD_W-STEP_W){1'b0}}, c.h};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] sat(logic [WORD_W:0] s);
    logic [WORD_W-1:0] v;
    if (s[WORD_W] != s[WORD_W-1]) begin
      v = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      v = s[WORD_W-1:0];
    end
    return v;
  endfunction

  // magnitude and sign back to a word, clamped to the signed range
  function automatic logic [WORD_W-1:0] from_mag(logic [MW-1:0] m, logic neg);
    logic [MW-1:0] lim;
    logic [MW-1:0] c;
    lim = neg ? (MW'(1) << (WORD_W-1)) : ((MW'(1) << (WORD_W-1)) - MW'(1));
    c   = (m > lim) ? lim : m;
    return neg ? (-c[WORD_W-1:0]) : c[WORD_W-1:0];
  endfunction

  assign spec_a = sel_spec(ctl_i.a, px_q, py_q, pz_q, cfg_i);
  assign spec_b = sel_spec(ctl_i.b, px_q, py_q, pz_q, cfg_i);

  // operand read, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      opa_q <= (ctl_i.a < R_NX) ? spec_a : mem[ctl_i.a];
      opb_q <= (ctl_i.b < R_NX) ? spec_b : mem[ctl_i.b];
    end
  end

  always_comb begin
    sum_c  = {opa_q[WORD_W-1], opa_q} + {opb_q[WORD_W-1], opb_q};
    dif_c  = {opa_q[WORD_W-1], opa_q} - {opb_q[WORD_W-1], opb_q};
    mag_a  = opa_q[WORD_W-1] ? -opa_q : opa_q;
    mag_b  = opb_q[WORD_W-1] ? -opb_q : opb_q;
    // divide by six: (|t| + 3) times the reciprocal of three, shifted
    mul_x  = (ctl_i.op == OP_MUL6) ? (mag_a + WORD_W'(3)) : mag_a;
    mul_y  = (ctl_i.op == OP_MUL6) ? RECIP3 : mag_b;
    prod_c = {{WORD_W{1'b0}}, mul_x} * {{WORD_W{1'b0}}, mul_y};
    rnd_c  = prod_q + (PROD_W'(1) << (FRAC_W-1));
    half_c = {1'b0, mag_a} + {{WORD_W{1'b0}}, 1'b1};
    half_m = half_c[WORD_W:1];
    case (ctl_i.op)
      OP_ADD:  res_c = sat(sum_c);
      OP_SUB:  res_c = sat(dif_c);
      OP_RND:  res_c = from_mag(rnd_c[PROD_W-1:FRAC_W], neg_q);
      OP_Q6:   res_c = from_mag({{(MW-QW){1'b0}}, prod_q[PROD_W-1:RECIP_SHIFT]}, neg_q);
      OP_DIV2: res_c = opa_q[WORD_W-1] ? -half_m : half_m;
      default: res_c = opa_q;
    endcase
    wr_en = ctl_i.ex && (ctl_i.op inside {OP_ADD, OP_SUB, OP_MOV, OP_RND, OP_Q6, OP_DIV2});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ex && (ctl_i.op == OP_MUL || ctl_i.op == OP_MUL6)) begin
      prod_q <= prod_c;
      neg_q  <= (ctl_i.op == OP_MUL6) ? opa_q[WORD_W-1]
                                      : (opa_q[WORD_W-1] ^ opb_q[WORD_W-1]);
    end
    if (wr_en && ctl_i.dst >= R_NX) begin
      mem[ctl_i.dst] <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (load_i) begin
      px_q <= load_x_i;
      py_q <= load_y_i;
      pz_q <= load_z_i;
    end else if (wr_en) begin
      case (ctl_i.dst)
        R_PX:    px_q <= res_c;
        R_PY:    py_q <= res_c;
        R_PZ:    pz_q <= res_c;
        default: ;
      endcase
    end
  end

  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign pos_z_o = pz_q;

endmodule

`default_nettype wire

// ===== rtl/lorenz_ode_integrator_top.sv =====
// ----------------------------------------------------------------------------
// lorenz_ode_integrator_top
// Lorenz system integrator, Q16.16, five methods, microcoded datapath.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | kind_i, load_x_i, load_y_i, load_z_i
//  out     | out_valid_o/ out_stall_i| out_x_o, out_y_o, out_z_o, step_count_o
//  cfg     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// Load: the point registers take the new point, then the output register copies
// it once free. Advance: control words run one at a time, each as an operand read
// then an execute, over the shared multiplier and register file port.
// Reset loads the default coefficients and clears point and count.
// Input stalls while an item runs or its result waits for the output register.
`default_nettype none

module lorenz_ode_integrator_top import lod_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [WORD_W-1:0] load_x_i,
  input  logic [WORD_W-1:0] load_y_i,
  input  logic [WORD_W-1:0] load_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] out_x_o,
  output logic [WORD_W-1:0] out_y_o,
  output logic [WORD_W-1:0] out_z_o,
  output logic [WORD_W-1:0] step_count_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              busy_q, pend_q, out_valid_q;
  logic [WORD_W-1:0] count_q;
  logic [WORD_W-1:0] out_x_q, out_y_q, out_z_q, out_cnt_q;
  logic              in_xfer, start, load, done, out_load;
  ctl_t              ctl;
  logic [WORD_W-1:0] pos_x, pos_y, pos_z;

  assign in_stall_o  = busy_q || pend_q;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign start       = in_xfer && kind_i;
  assign load        = in_xfer && !kind_i;
  assign out_load    = pend_q && (!out_valid_q || !out_stall_i);

  lod_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .method_i (cfg_q.method),
    .ctl_o    (ctl),
    .done_o   (done)
  );

  lod_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .load_i   (load),
    .load_x_i (load_x_i),
    .load_y_i (load_y_i),
    .load_z_i (load_z_i),
    .pos_x_o  (pos_x),
    .pos_y_o  (pos_y),
    .pos_z_o  (pos_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method <= M_RK4;
      cfg_q.sigma  <= 32'd655360;
      cfg_q.rho    <= 32'd1835008;
      cfg_q.beta   <= 32'd174763;
      cfg_q.h      <= 17'd655;
      busy_q       <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_METHOD: cfg_q.method <= cfg_data_i[METHOD_W-1:0];
          CFG_SIGMA:  cfg_q.sigma  <= cfg_data_i;
          CFG_RHO:    cfg_q.rho    <= cfg_data_i;
          CFG_BETA:   cfg_q.beta   <= cfg_data_i;
          CFG_STEP:   cfg_q.h      <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (start) busy_q <= 1'b1;
      if (load) begin
        count_q <= '0;
        pend_q  <= 1'b1;
      end
      if (done) begin
        busy_q  <= 1'b0;
        pend_q  <= 1'b1;
        count_q <= count_q + WORD_W'(1);
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q   <= pos_x;
      out_y_q   <= pos_y;
      out_z_q   <= pos_z;
      out_cnt_q <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign step_count_o = out_cnt_q;

endmodule

`default_nettype wire

// ===== rtl/lod_checker.sv =====
// ----------------------------------------------------------------------------
// lod_checker
// Port-level checks of the integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lod_checker import lod_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              kind_i,
  input logic [WORD_W-1:0] load_x_i,
  input logic [WORD_W-1:0] load_y_i,
  input logic [WORD_W-1:0] load_z_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [WORD_W-1:0] out_x_o,
  input logic [WORD_W-1:0] out_y_o,
  input logic [WORD_W-1:0] out_z_o,
  input logic [WORD_W-1:0] step_count_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  `LOD_ASSERT(a_out_hold,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_x_o) &&
      $stable(out_y_o) && $stable(out_z_o) && $stable(step_count_o)),
    "output dropped under stall")

  // one item in flight: the transfer itself closes the input
  `LOD_ASSERT(a_one_item, in_xfer |=> in_stall_o, "input taken while an item is in flight")

  // a load into an empty output passes through the point registers to the output registers with a cleared count
  `LOD_ASSERT_CLK(a_load_echo, clk_i, rst_ni,
    (in_xfer && !kind_i && !out_valid_o) |-> ##2 (out_valid_o &&
      out_x_o == $past(load_x_i, 2) && out_y_o == $past(load_y_i, 2) &&
      out_z_o == $past(load_z_i, 2) && step_count_o == '0),
    "load result wrong")

endmodule

bind lorenz_ode_integrator_top lod_checker u_lod_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Lorenz integrator: a queue-fed driver sends
// load and advance items in bursts, a monitor compares every output transfer
// with a point predicted in Q16.16, and configuration changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lod_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_SPARE = 3'd5;  // no register at this index
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 320;

  typedef longint trip_t [3];

  typedef struct {
    logic              kind;
    logic [WORD_W-1:0] x, y, z;
  } item_t;

  typedef struct {
    logic [WORD_W-1:0] x, y, z, cnt;
  } point_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              kind_i = 1'b0;
  logic [WORD_W-1:0] load_x_i = '0, load_y_i = '0, load_z_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [WORD_W-1:0] out_x_o, out_y_o, out_z_o, step_count_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0] cfg_data_i = '0;

  lorenz_ode_integrator_top i_dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // shadow copy of the block: configuration and point
  logic [METHOD_W-1:0] mdl_method = M_RK4;
  longint mdl_sigma = 655360, mdl_rho = 1835008, mdl_beta = 174763, mdl_h = 655;
  trip_t  mdl_pt = '{0, 0, 0};
  logic [31:0] mdl_steps = '0;

  item_t  pending_q[$];
  point_t expected_q[$];
  int     n_err = 0;

  function automatic longint sat_w(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic longint q_add(longint a, longint b);
    return sat_w(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return sat_w(a - b);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint ma, mb, r;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    r   = (ma * mb + 64'sd32768) >>> 16;
    return sat_w(neg ? -r : r);
  endfunction

  // h * k rounded, then divided by div and rounded again, ties away from zero
  function automatic longint h_scale(longint k, longint div);
    longint t, m, q;
    t = q_mul(mdl_h, k);
    m = t < 0 ? -t : t;
    q = m / div + (((m % div) * 2 >= div) ? 1 : 0);
    return sat_w(t < 0 ? -q : q);
  endfunction

  function automatic void lorenz_deriv(input trip_t p, output trip_t d);
    d[0] = q_mul(mdl_sigma, q_sub(p[1], p[0]));
    d[1] = q_sub(q_mul(p[0], q_sub(mdl_rho, p[2])), p[1]);
    d[2] = q_sub(q_mul(p[0], p[1]), q_mul(mdl_beta, p[2]));
  endfunction

  function automatic void integrate_step();
    trip_t p, n, d, k1, k2, k3, k4, t;
    longint s;
    int ax;
    p = mdl_pt;
    n = p;
    case (mdl_method)
      M_EULER: begin
        lorenz_deriv(p, d);
        for (int i = 0; i < 3; i++) n[i] = q_add(p[i], h_scale(d[i], 1));
      end
      M_RK4: begin
        lorenz_deriv(p, k1);
        for (int i = 0; i < 3; i++) t[i] = q_add(p[i], h_scale(k1[i], 2));
        lorenz_deriv(t, k2);
        for (int i = 0; i < 3; i++) t[i] = q_add(p[i], h_scale(k2[i], 2));
        lorenz_deriv(t, k3);
        for (int i = 0; i < 3; i++) t[i] = q_add(p[i], h_scale(k3[i], 1));
        lorenz_deriv(t, k4);
        for (int i = 0; i < 3; i++) begin
          s = q_add(k1[i], q_add(k2[i], k2[i]));
          s = q_add(q_add(s, q_add(k3[i], k3[i])), k4[i]);
          n[i] = q_add(p[i], h_scale(s, 6));
        end
      end
      M_MID: begin
        lorenz_deriv(p, k1);
        for (int i = 0; i < 3; i++) t[i] = q_add(p[i], h_scale(k1[i], 2));
        lorenz_deriv(t, k2);
        for (int i = 0; i < 3; i++) n[i] = q_add(p[i], h_scale(k2[i], 1));
      end
      M_EC: begin
        for (int i = 0; i < 3; i++) begin
          lorenz_deriv(n, d);
          n[i] = q_add(p[i], h_scale(d[i], 1));
        end
      end
      M_SYM: begin
        for (int i = 0; i < 6; i++) begin
          ax = i < 3 ? i : 5 - i;
          lorenz_deriv(n, d);
          n[ax] = q_add(n[ax], h_scale(d[ax], 2));
        end
      end
      default: ;  // spare codes hold the point
    endcase
    mdl_pt = n;
    mdl_steps = mdl_steps + 1;
  endfunction

  function automatic void predict_point(item_t it);
    point_t e;
    if (!it.kind) begin
      mdl_pt[0] = longint'($signed(it.x));
      mdl_pt[1] = longint'($signed(it.y));
      mdl_pt[2] = longint'($signed(it.z));
      mdl_steps = '0;
    end else begin
      integrate_step();
    end
    e.x = mdl_pt[0][31:0];
    e.y = mdl_pt[1][31:0];
    e.z = mdl_pt[2][31:0];
    e.cnt = mdl_steps;
    expected_q.push_back(e);
  endfunction

  // ---------------------------------------------------------------- driver
  int burst_left = 1, gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_point(pending_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          kind_i   <= pending_q[0].kind;
          load_x_i <= pending_q[0].x;
          load_y_i <= pending_q[0].y;
          load_z_i <= pending_q[0].z;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int stall_mode = 0, mode_cnt = 0, stall_hold = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("output transfer with no pending point");
          n_err++;
        end else begin
          point_t e;
          e = expected_q.pop_front();
          if (out_x_o !== e.x) begin
            $error("out_x expected %h got %h", e.x, out_x_o); n_err++;
          end
          if (out_y_o !== e.y) begin
            $error("out_y expected %h got %h", e.y, out_y_o); n_err++;
          end
          if (out_z_o !== e.z) begin
            $error("out_z expected %h got %h", e.z, out_z_o); n_err++;
          end
          if (step_count_o !== e.cnt) begin
            $error("step_count expected %h got %h", e.cnt, step_count_o); n_err++;
          end
        end
      end
    end
    // stall pattern: the mode changes each time mode_cnt runs out
    if (mode_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_cnt   = $urandom_range(100, 600);
    end
    mode_cnt--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 7) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
        end else begin
          stall_hold = $urandom_range(1, 40);
          out_stall_i <= ~out_stall_i;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_METHOD: mdl_method = data[METHOD_W-1:0];
      CFG_SIGMA:  mdl_sigma = longint'($signed(data));
      CFG_RHO:    mdl_rho = longint'($signed(data));
      CFG_BETA:   mdl_beta = longint'($signed(data));
      CFG_STEP:   mdl_h = longint'(data[STEP_W-1:0]);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_item(logic k, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z);
    item_t it;
    it.kind = k; it.x = x; it.y = y; it.z = z;
    pending_q.push_back(it);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 60 << 16) - (30 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(int nominal);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return nominal + $urandom_range(0, 4 << 16) - (2 << 16);
    endcase
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    int left;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset configuration, extreme points
    push_item(1'b1, '0, '0, '0);
    push_item(1'b0, '0, '0, '0);
    push_item(1'b1, '0, '0, '0);
    push_item(1'b0, ONE, ONE, ONE);
    push_item(1'b1, '0, '0, '0);
    push_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(1'b1, '0, '0, '0);
    push_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_item(1'b1, '1, '1, '1);
    push_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    push_item(1'b1, '0, '0, '0);
    drain();

    // every method code, spare ones included, plus the spare register index
    write_reg(CFG_SPARE, $urandom());
    for (int m = 0; m < 8; m++) begin
      write_reg(CFG_METHOD, m);
      push_item(1'b0, ONE, 2 * ONE, 3 * ONE);
      push_item(1'b1, '0, '0, '0);
      drain();
    end

    // random phases; the first two pin coefficients and step to extremes, the third sets step 1
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_METHOD, ($urandom_range(0, 9) == 0) ?
                $urandom_range(5, 7) : $urandom_range(0, 4));
      case (ph)
        0: begin
          write_reg(CFG_SIGMA, 32'h7FFF_FFFF); write_reg(CFG_RHO, 32'h8000_0000);
          write_reg(CFG_BETA, 32'h7FFF_FFFF);  write_reg(CFG_STEP, 65536);
        end
        1: begin
          write_reg(CFG_SIGMA, 32'h8000_0000); write_reg(CFG_RHO, 32'h7FFF_FFFF);
          write_reg(CFG_BETA, 32'h8000_0000);  write_reg(CFG_STEP, 0);
        end
        2: write_reg(CFG_STEP, 1);
        default: begin
          write_reg(CFG_SIGMA, rand_coef(655360));
          write_reg(CFG_RHO, rand_coef(1835008));
          write_reg(CFG_BETA, rand_coef(174763));
          write_reg(CFG_STEP, ($urandom_range(0, 4) == 0) ?
                    $urandom_range(1, 65536) : $urandom_range(1, 3000));
        end
      endcase
      left = 80;
      while (left > 0) begin
        if ($urandom_range(0, 6) != 0) begin
          // well-formed: a load followed by a run of advances
          push_item(1'b0, rand_coord(), rand_coord(), rand_coord());
          left--;
          for (int n = $urandom_range(3, 30); n > 0 && left > 0; n--) begin
            push_item(1'b1, $urandom(), $urandom(), $urandom());
            left--;
          end
        end else begin
          push_item(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
          left--;
        end
      end
      drain();
    end

    if (n_err == 0) begin
      $display("[lorenz_ode_integrator_top] OK");
    end else begin
      $display("[lorenz_ode_integrator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[lorenz_ode_integrator_top] ERROR");
    $finish;
  end

endmodule
